>>> src/ccp_pkg.sv
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared types and constants of the chunk container parser: payload
// structs, header ids, byte role codes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ccp_pkg;

	localparam int LENGTH_BITS_DEF = 32;
	localparam int COUNT_BITS      = 33;

	localparam logic [31:0] ID_CAT  = 32'h4341_5420;
	localparam logic [31:0] ID_PRBM = 32'h5052_424D;
	localparam logic [31:0] ID_HEAD = 32'h4845_4144;
	localparam logic [31:0] ID_EMBF = 32'h454D_4246;
	localparam logic [31:0] ID_INFO = 32'h494E_464F;

	localparam int ROOT_HDR_BYTES = 12;
	localparam int COPY_OFFSET    = 9;

	// byte roles
	localparam logic [3:0] ROLE_ROOT_HDR  = 4'd0;
	localparam logic [3:0] ROLE_CHUNK_HDR = 4'd1;
	localparam logic [3:0] ROLE_COPYRIGHT = 4'd2;
	localparam logic [3:0] ROLE_HEAD      = 4'd3;
	localparam logic [3:0] ROLE_NAME      = 4'd4;
	localparam logic [3:0] ROLE_NAME_END  = 4'd5;
	localparam logic [3:0] ROLE_PAYLOAD   = 4'd6;
	localparam logic [3:0] ROLE_INFO      = 4'd7;
	localparam logic [3:0] ROLE_UNKNOWN   = 4'd8;
	localparam logic [3:0] ROLE_PAD       = 4'd9;
	localparam logic [3:0] ROLE_IGNORED   = 4'd10;

	// verdict codes
	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_SHORT       = 4'd1;
	localparam logic [3:0] ST_MAGIC       = 4'd2;
	localparam logic [3:0] ST_ROOT_SIZE   = 4'd3;
	localparam logic [3:0] ST_MARKER      = 4'd4;
	localparam logic [3:0] ST_BOUNDS      = 4'd5;
	localparam logic [3:0] ST_HEAD_SMALL  = 4'd6;
	localparam logic [3:0] ST_EMBF_SMALL  = 4'd7;
	localparam logic [3:0] ST_NO_NAME     = 4'd8;
	localparam logic [3:0] ST_NO_RESOURCE = 4'd9;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  byte_role;
		logic        chunk_start;
		logic        chunk_end;
		logic [31:0] body_offset;
		logic        verdict_valid;
		logic [3:0]  status;
		logic [15:0] resource_count;
	} out_item_t;

	// header and list condition flags handed to the verdict logic
	typedef struct packed {
		logic       magic_bad;
		logic       marker_bad;
		logic [3:0] first_error;
		logic       any_embf;
	} verdict_flags_t;

endpackage

`default_nettype wire

>>> src/chunk_container_parser.sv
// ----------------------------------------------------------------------------
// chunk_container_parser
// Streaming parser for a chunked container file: tags each byte with its
// role, checks root header and chunk rules and reports the verdict on the
// last byte.
// ----------------------------------------------------------------------------
// Datapath: each accepted byte is captured in the input register, then one
//   pass of parse logic writes the result register that drives out_valid.
// Takes one byte per cycle while out_ready does not stall the result stage.
// Reset: arst_n clears the parser to the root header state; after each
//   last byte the parser returns to that state for the next file.
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_container_parser #(
	parameter int LENGTH_BITS = ccp_pkg::LENGTH_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire ccp_pkg::in_item_t   in_data,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      ccp_pkg::out_item_t  out_data
);

	localparam int CB = ccp_pkg::COUNT_BITS;

	localparam logic [1:0] K_OTHER = 2'd0;
	localparam logic [1:0] K_HEAD  = 2'd1;
	localparam logic [1:0] K_EMBF  = 2'd2;
	localparam logic [1:0] K_INFO  = 2'd3;

	localparam logic [3:0] IDX_MAGIC  = 4'd3;
	localparam logic [3:0] IDX_SIZE   = 4'd7;
	localparam logic [3:0] IDX_MARKER = 4'd11;

	typedef enum logic [2:0] {
		PH_ROOT,
		PH_HDR,
		PH_BODY,
		PH_PAD,
		PH_IDLE
	} phase_t;

	// input stage
	logic               valid_s1;
	ccp_pkg::in_item_t  item_s1;

	// result stage
	logic               res_valid_s2;
	ccp_pkg::out_item_t res_s2;

	// parse state
	phase_t                 phase_q,     phase_n;
	logic [3:0]             hdr_idx_q,   hdr_idx_n;
	logic [31:0]            shift_q,     shift_n;
	logic [CB-1:0]          count_q,     count_n;
	logic [LENGTH_BITS-1:0] list_rem_q,  list_rem_n;
	logic [1:0]             kind_q,      kind_n;
	logic [LENGTH_BITS-1:0] chunk_left_q, chunk_left_n;
	logic [LENGTH_BITS-1:0] chunk_pos_q, chunk_pos_n;
	logic                   zero_seen_q, zero_seen_n;
	logic                   pad_pend_q,  pad_pend_n;
	logic [3:0]             first_err_q, first_err_n;
	logic [15:0]            embf_q,      embf_n;
	logic [LENGTH_BITS-1:0] root_size_q, root_size_n;
	logic                   magic_bad_q, magic_bad_n;
	logic                   marker_bad_q, marker_bad_n;

	logic                    advance;
	logic                    step;
	logic [31:0]             word;
	logic [LENGTH_BITS-1:0]  sz;
	logic [LENGTH_BITS-1:0]  lr_hdr;
	logic [LENGTH_BITS-1:0]  lr_dec;
	logic [LENGTH_BITS-1:0]  left_dec;
	logic                    past_copy;
	logic                    name_err;
	ccp_pkg::out_item_t      res_n;
	ccp_pkg::out_item_t      res_w;
	ccp_pkg::verdict_flags_t vflags;
	logic [3:0]              status_w;

	assign advance  = !res_valid_s2 || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	assign word      = {shift_q[23:0], item_s1.in_byte};
	assign sz        = word[LENGTH_BITS-1:0];
	assign lr_hdr    = list_rem_q - LENGTH_BITS'(8);
	assign lr_dec    = list_rem_q - LENGTH_BITS'(1);
	assign left_dec  = chunk_left_q - LENGTH_BITS'(1);
	assign past_copy = chunk_pos_q >= LENGTH_BITS'(ccp_pkg::COPY_OFFSET);

	always_comb begin
		phase_n      = phase_q;
		hdr_idx_n    = hdr_idx_q;
		shift_n      = shift_q;
		count_n      = (count_q != '1) ? count_q + CB'(1) : count_q;
		list_rem_n   = list_rem_q;
		kind_n       = kind_q;
		chunk_left_n = chunk_left_q;
		chunk_pos_n  = chunk_pos_q;
		zero_seen_n  = zero_seen_q;
		pad_pend_n   = pad_pend_q;
		first_err_n  = first_err_q;
		embf_n       = embf_q;
		root_size_n  = root_size_q;
		magic_bad_n  = magic_bad_q;
		marker_bad_n = marker_bad_q;
		name_err     = 1'b0;

		res_n               = '0;
		res_n.byte_role     = ccp_pkg::ROLE_IGNORED;
		res_n.verdict_valid = item_s1.last_byte;

		case (phase_q)
			PH_ROOT: begin
				res_n.byte_role = ccp_pkg::ROLE_ROOT_HDR;
				shift_n         = word;
				if (hdr_idx_q == IDX_MAGIC) begin
					magic_bad_n = word != ccp_pkg::ID_CAT;
				end else if (hdr_idx_q == IDX_SIZE) begin
					root_size_n = sz;
				end
				if (hdr_idx_q == IDX_MARKER) begin
					marker_bad_n = word != ccp_pkg::ID_PRBM;
					if (root_size_q >= LENGTH_BITS'(4)) begin
						list_rem_n = root_size_q - LENGTH_BITS'(4);
						hdr_idx_n  = '0;
						phase_n    = (list_rem_n >= LENGTH_BITS'(8)) ? PH_HDR : PH_IDLE;
					end else begin
						phase_n = PH_IDLE;
					end
				end else begin
					hdr_idx_n = hdr_idx_q + 4'd1;
				end
			end
			PH_HDR: begin
				res_n.byte_role = ccp_pkg::ROLE_CHUNK_HDR;
				shift_n         = word;
				if (hdr_idx_q == IDX_MAGIC) begin
					if (word == ccp_pkg::ID_HEAD) begin
						kind_n = K_HEAD;
					end else if (word == ccp_pkg::ID_EMBF) begin
						kind_n = K_EMBF;
					end else if (word == ccp_pkg::ID_INFO) begin
						kind_n = K_INFO;
					end else begin
						kind_n = K_OTHER;
					end
					hdr_idx_n = hdr_idx_q + 4'd1;
				end else if (hdr_idx_q == IDX_SIZE) begin
					list_rem_n = lr_hdr;
					if (sz > lr_hdr) begin
						first_err_n = ccp_pkg::ST_BOUNDS;
						phase_n     = PH_IDLE;
					end else if (kind_q == K_HEAD && sz < LENGTH_BITS'(4)) begin
						first_err_n = ccp_pkg::ST_HEAD_SMALL;
						phase_n     = PH_IDLE;
					end else if (kind_q == K_EMBF && sz < LENGTH_BITS'(2)) begin
						first_err_n = ccp_pkg::ST_EMBF_SMALL;
						phase_n     = PH_IDLE;
					end else if (sz == '0) begin
						hdr_idx_n = '0;
						phase_n   = (lr_hdr >= LENGTH_BITS'(8)) ? PH_HDR : PH_IDLE;
					end else begin
						phase_n      = PH_BODY;
						chunk_left_n = sz;
						chunk_pos_n  = '0;
						zero_seen_n  = 1'b0;
						pad_pend_n   = sz[0];
					end
				end else begin
					hdr_idx_n = hdr_idx_q + 4'd1;
				end
			end
			PH_BODY: begin
				res_n.body_offset = 32'(chunk_pos_q);
				res_n.chunk_start = chunk_pos_q == '0;
				res_n.chunk_end   = chunk_left_q == LENGTH_BITS'(1);
				case (kind_q)
					K_HEAD: begin
						if (past_copy && !zero_seen_q && item_s1.in_byte != 8'd0) begin
							res_n.byte_role = ccp_pkg::ROLE_COPYRIGHT;
						end else begin
							res_n.byte_role = ccp_pkg::ROLE_HEAD;
							if (past_copy) begin
								zero_seen_n = 1'b1;
							end
						end
					end
					K_EMBF: begin
						if (zero_seen_q) begin
							res_n.byte_role = ccp_pkg::ROLE_PAYLOAD;
						end else if (item_s1.in_byte != 8'd0) begin
							res_n.byte_role = ccp_pkg::ROLE_NAME;
						end else begin
							res_n.byte_role = ccp_pkg::ROLE_NAME_END;
							zero_seen_n     = 1'b1;
							if (chunk_pos_q == '0) begin
								name_err = 1'b1;
							end else if (embf_q != 16'hFFFF) begin
								embf_n = embf_q + 16'd1;
							end
						end
					end
					K_INFO: begin
						res_n.byte_role = ccp_pkg::ROLE_INFO;
					end
					default: begin
						res_n.byte_role = ccp_pkg::ROLE_UNKNOWN;
					end
				endcase
				list_rem_n   = lr_dec;
				chunk_left_n = left_dec;
				chunk_pos_n  = chunk_pos_q + LENGTH_BITS'(1);
				if (name_err) begin
					first_err_n = ccp_pkg::ST_NO_NAME;
					phase_n     = PH_IDLE;
				end else if (left_dec == '0) begin
					if (kind_q == K_EMBF && !zero_seen_n) begin
						first_err_n = ccp_pkg::ST_NO_NAME;
						phase_n     = PH_IDLE;
					end else if (pad_pend_q && lr_dec != '0) begin
						phase_n = PH_PAD;
					end else begin
						hdr_idx_n = '0;
						phase_n   = (lr_dec >= LENGTH_BITS'(8)) ? PH_HDR : PH_IDLE;
					end
				end
			end
			PH_PAD: begin
				res_n.byte_role = ccp_pkg::ROLE_PAD;
				list_rem_n      = lr_dec;
				hdr_idx_n       = '0;
				phase_n         = (lr_dec >= LENGTH_BITS'(8)) ? PH_HDR : PH_IDLE;
			end
			default: begin
				res_n.byte_role = ccp_pkg::ROLE_IGNORED;
			end
		endcase

		res_n.resource_count = embf_n;
	end

	assign vflags.magic_bad   = magic_bad_n;
	assign vflags.marker_bad  = marker_bad_n;
	assign vflags.first_error = first_err_n;
	assign vflags.any_embf    = embf_n != 16'd0;

	ccp_verdict #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_verdict (
		.byte_count(count_n),
		.root_size (root_size_n),
		.flags     (vflags),
		.status    (status_w)
	);

	// status is only reported on the last byte of a file
	always_comb begin
		res_w        = res_n;
		res_w.status = item_s1.last_byte ? status_w : ccp_pkg::ST_OK;
	end

	// control: stage valids and parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_s2 <= 1'b0;
			phase_q      <= PH_ROOT;
			hdr_idx_q    <= '0;
			shift_q      <= '0;
			count_q      <= '0;
			list_rem_q   <= '0;
			kind_q       <= K_OTHER;
			chunk_left_q <= '0;
			chunk_pos_q  <= '0;
			zero_seen_q  <= 1'b0;
			pad_pend_q   <= 1'b0;
			first_err_q  <= ccp_pkg::ST_OK;
			embf_q       <= '0;
			root_size_q  <= '0;
			magic_bad_q  <= 1'b0;
			marker_bad_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				res_valid_s2 <= valid_s1;
			end
			if (step) begin
				if (item_s1.last_byte) begin
					// end of file: start over for the next one
					phase_q      <= PH_ROOT;
					hdr_idx_q    <= '0;
					shift_q      <= '0;
					count_q      <= '0;
					list_rem_q   <= '0;
					kind_q       <= K_OTHER;
					chunk_left_q <= '0;
					chunk_pos_q  <= '0;
					zero_seen_q  <= 1'b0;
					pad_pend_q   <= 1'b0;
					first_err_q  <= ccp_pkg::ST_OK;
					embf_q       <= '0;
					root_size_q  <= '0;
					magic_bad_q  <= 1'b0;
					marker_bad_q <= 1'b0;
				end else begin
					phase_q      <= phase_n;
					hdr_idx_q    <= hdr_idx_n;
					shift_q      <= shift_n;
					count_q      <= count_n;
					list_rem_q   <= list_rem_n;
					kind_q       <= kind_n;
					chunk_left_q <= chunk_left_n;
					chunk_pos_q  <= chunk_pos_n;
					zero_seen_q  <= zero_seen_n;
					pad_pend_q   <= pad_pend_n;
					first_err_q  <= first_err_n;
					embf_q       <= embf_n;
					root_size_q  <= root_size_n;
					magic_bad_q  <= magic_bad_n;
					marker_bad_q <= marker_bad_n;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (step) begin
			res_s2 <= res_w;
		end
	end

	assign out_valid = res_valid_s2;
	assign out_data  = res_s2;

	a_status_only_on_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.verdict_valid) |-> (out_data.status == ccp_pkg::ST_OK))
		else $error("status set on a non-final byte");

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.last_byte) |=> (phase_q == PH_ROOT && count_q == '0))
		else $error("parser did not return to root header after last byte");

	a_start_at_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.chunk_start) |-> (out_data.body_offset == 32'd0))
		else $error("chunk start flagged away from body offset zero");

	a_idle_ignores: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_IDLE) |=> (res_s2.byte_role == ccp_pkg::ROLE_IGNORED))
		else $error("byte after the chunk list not tagged ignored");

endmodule

`default_nettype wire

>>> src/ccp_verdict.sv
// ----------------------------------------------------------------------------
// ccp_verdict
// Ranks the header and list faults of one file into its final status code.
// ----------------------------------------------------------------------------
`default_nettype none

module ccp_verdict #(
	parameter int LENGTH_BITS = ccp_pkg::LENGTH_BITS_DEF
) (
	input  wire logic [ccp_pkg::COUNT_BITS-1:0] byte_count,
	input  wire logic [LENGTH_BITS-1:0]         root_size,
	input  wire ccp_pkg::verdict_flags_t        flags,
	output      logic [3:0]                     status
);

	logic [ccp_pkg::COUNT_BITS-1:0] size_limit;
	logic                           size_bad;

	assign size_limit = byte_count - ccp_pkg::COUNT_BITS'(8);
	assign size_bad   = (root_size < LENGTH_BITS'(4))
		|| (ccp_pkg::COUNT_BITS'(root_size) > size_limit);

	always_comb begin
		if (byte_count < ccp_pkg::COUNT_BITS'(ccp_pkg::ROOT_HDR_BYTES)) begin
			status = ccp_pkg::ST_SHORT;
		end else if (flags.magic_bad) begin
			status = ccp_pkg::ST_MAGIC;
		end else if (size_bad) begin
			status = ccp_pkg::ST_ROOT_SIZE;
		end else if (flags.marker_bad) begin
			status = ccp_pkg::ST_MARKER;
		end else if (flags.first_error != ccp_pkg::ST_OK) begin
			status = flags.first_error;
		end else if (!flags.any_embf) begin
			status = ccp_pkg::ST_NO_RESOURCE;
		end else begin
			status = ccp_pkg::ST_OK;
		end
	end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for chunk_container_parser. Container files are built
// on the fly: well-formed chunk lists with random bodies, files with one
// broken chunk or a damaged root header, truncated files and raw noise.
// A byte-level predictor tags every accepted byte, and each result is
// checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int HOLD_CYCLES = 400;

	// Byte-role predictor plus the queue of tags still owed by the block.
	class tag_board;
		typedef enum logic [2:0] {P_ROOT, P_HDR, P_BODY, P_PAD, P_IDLE} parse_phase_e;
		typedef enum logic [1:0] {K_OTHER, K_HEAD, K_EMBF, K_INFO} chunk_kind_e;

		parse_phase_e phase;
		chunk_kind_e  kind;
		logic [3:0]   hdr_idx;
		logic [31:0]  word;
		logic [32:0]  seen_bytes;
		logic [31:0]  list_left;
		logic [31:0]  body_left;
		logic [31:0]  body_pos;
		logic         zero_seen;
		logic         pad_due;
		logic [3:0]   first_error;
		logic [15:0]  embf_count;
		logic [31:0]  root_size;
		logic         magic_bad;
		logic         marker_bad;
		logic [31:0]  len_mask;
		ccp_pkg::out_item_t tags_due[$];
		int           mismatches;

		function new();
			len_mask = 32'hFFFF_FFFF >> (32 - ccp_pkg::LENGTH_BITS_DEF);
			mismatches = 0;
			clear_file();
		endfunction

		function void clear_file();
			phase = P_ROOT;
			kind = K_OTHER;
			hdr_idx = '0;
			word = '0;
			seen_bytes = '0;
			list_left = '0;
			body_left = '0;
			body_pos = '0;
			zero_seen = 1'b0;
			pad_due = 1'b0;
			first_error = ccp_pkg::ST_OK;
			embf_count = '0;
			root_size = '0;
			magic_bad = 1'b0;
			marker_bad = 1'b0;
		endfunction

		function void open_chunk();
			hdr_idx = '0;
			phase = (list_left >= 32'd8) ? P_HDR : P_IDLE;
		endfunction

		function void stop_list(logic [3:0] code);
			first_error = code;
			phase = P_IDLE;
		endfunction

		function int pending();
			return tags_due.size();
		endfunction

		function void note_byte(ccp_pkg::in_item_t it);
			ccp_pkg::out_item_t t;
			logic [7:0]  b;
			logic [31:0] sz;
			logic        name_err;
			b = it.in_byte;
			t = '0;
			t.byte_role = ccp_pkg::ROLE_IGNORED;
			name_err = 1'b0;
			if (seen_bytes != '1)
				seen_bytes++;
			case (phase)
				P_ROOT: begin
					t.byte_role = ccp_pkg::ROLE_ROOT_HDR;
					word = {word[23:0], b};
					if (hdr_idx == 4'd3)
						magic_bad = (word != ccp_pkg::ID_CAT);
					else if (hdr_idx == 4'd7)
						root_size = word & len_mask;
					if (hdr_idx == 4'd11) begin
						marker_bad = (word != ccp_pkg::ID_PRBM);
						if (root_size >= 32'd4) begin
							list_left = root_size - 32'd4;
							open_chunk();
						end else begin
							phase = P_IDLE;
						end
					end else begin
						hdr_idx++;
					end
				end
				P_HDR: begin
					t.byte_role = ccp_pkg::ROLE_CHUNK_HDR;
					word = {word[23:0], b};
					if (hdr_idx == 4'd3) begin
						kind = (word == ccp_pkg::ID_HEAD) ? K_HEAD :
						       (word == ccp_pkg::ID_EMBF) ? K_EMBF :
						       (word == ccp_pkg::ID_INFO) ? K_INFO : K_OTHER;
						hdr_idx++;
					end else if (hdr_idx == 4'd7) begin
						sz = word & len_mask;
						list_left -= 32'd8;
						if (sz > list_left)
							stop_list(ccp_pkg::ST_BOUNDS);
						else if (kind == K_HEAD && sz < 32'd4)
							stop_list(ccp_pkg::ST_HEAD_SMALL);
						else if (kind == K_EMBF && sz < 32'd2)
							stop_list(ccp_pkg::ST_EMBF_SMALL);
						else if (sz == 32'd0)
							open_chunk();
						else begin
							phase = P_BODY;
							body_left = sz;
							body_pos = '0;
							zero_seen = 1'b0;
							pad_due = sz[0];
						end
					end else begin
						hdr_idx++;
					end
				end
				P_BODY: begin
					t.body_offset = body_pos;
					t.chunk_start = (body_pos == 32'd0);
					t.chunk_end = (body_left == 32'd1);
					case (kind)
						K_HEAD: begin
							if (body_pos >= ccp_pkg::COPY_OFFSET && !zero_seen
							    && b != 8'd0) begin
								t.byte_role = ccp_pkg::ROLE_COPYRIGHT;
							end else begin
								t.byte_role = ccp_pkg::ROLE_HEAD;
								if (body_pos >= ccp_pkg::COPY_OFFSET)
									zero_seen = 1'b1;
							end
						end
						K_EMBF: begin
							if (zero_seen) begin
								t.byte_role = ccp_pkg::ROLE_PAYLOAD;
							end else if (b != 8'd0) begin
								t.byte_role = ccp_pkg::ROLE_NAME;
							end else begin
								t.byte_role = ccp_pkg::ROLE_NAME_END;
								zero_seen = 1'b1;
								if (body_pos == 32'd0)
									name_err = 1'b1;
								else if (embf_count != 16'hFFFF)
									embf_count++;
							end
						end
						K_INFO: t.byte_role = ccp_pkg::ROLE_INFO;
						default: t.byte_role = ccp_pkg::ROLE_UNKNOWN;
					endcase
					list_left--;
					body_left--;
					body_pos++;
					if (name_err) begin
						stop_list(ccp_pkg::ST_NO_NAME);
					end else if (body_left == 32'd0) begin
						if (kind == K_EMBF && !zero_seen)
							stop_list(ccp_pkg::ST_NO_NAME);
						else if (pad_due && list_left != 32'd0)
							phase = P_PAD;
						else
							open_chunk();
					end
				end
				P_PAD: begin
					t.byte_role = ccp_pkg::ROLE_PAD;
					list_left--;
					open_chunk();
				end
				default: ;
			endcase
			t.verdict_valid = it.last_byte;
			t.status = ccp_pkg::ST_OK;
			if (it.last_byte) begin
				if (seen_bytes < 33'd12)
					t.status = ccp_pkg::ST_SHORT;
				else if (magic_bad)
					t.status = ccp_pkg::ST_MAGIC;
				else if (root_size < 32'd4 || {1'b0, root_size} > seen_bytes - 33'd8)
					t.status = ccp_pkg::ST_ROOT_SIZE;
				else if (marker_bad)
					t.status = ccp_pkg::ST_MARKER;
				else if (first_error != ccp_pkg::ST_OK)
					t.status = first_error;
				else if (embf_count == 16'd0)
					t.status = ccp_pkg::ST_NO_RESOURCE;
			end
			t.resource_count = embf_count;
			tags_due.insert(tags_due.size(), t);
			if (it.last_byte)
				clear_file();
		endfunction

		function void check_result(ccp_pkg::out_item_t got);
			ccp_pkg::out_item_t want;
			if (tags_due.size() == 0) begin
				if (mismatches < 10)
					$display("tb_top: result with nothing pending, role=%0d", got.byte_role);
				mismatches++;
				return;
			end
			want = tags_due.pop_front();
			if (got.byte_role !== want.byte_role || got.chunk_start !== want.chunk_start ||
			    got.chunk_end !== want.chunk_end || got.body_offset !== want.body_offset ||
			    got.verdict_valid !== want.verdict_valid || got.status !== want.status ||
			    got.resource_count !== want.resource_count) begin
				if (mismatches < 10) begin
					$display("tb_top: mismatch exp role=%0d cs=%0d ce=%0d off=%0d vv=%0d st=%0d rc=%0d",
					         want.byte_role, want.chunk_start, want.chunk_end, want.body_offset,
					         want.verdict_valid, want.status, want.resource_count);
					$display("tb_top: mismatch got role=%0d cs=%0d ce=%0d off=%0d vv=%0d st=%0d rc=%0d",
					         got.byte_role, got.chunk_start, got.chunk_end, got.body_offset,
					         got.verdict_valid, got.status, got.resource_count);
				end
				mismatches++;
			end
		endfunction
	endclass

	typedef enum int {
		SH_HEAD, SH_EMBF, SH_INFO, SH_OTHER, SH_EMPTY,
		SH_BAD_BOUNDS, SH_HEAD_SMALL, SH_EMBF_SMALL, SH_NO_NAME, SH_UNTERMINATED
	} chunk_shape_e;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	ccp_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_ready;
	ccp_pkg::out_item_t out_data;

	tag_board   board;
	logic [7:0] file_q[$];
	logic [7:0] list_q[$];
	int         bytes_sent;
	int         send_idle_pct;
	int         recv_idle_pct;
	int         hold_req;
	int         hold_done;
	int         hold_left;
	int         cycle_count = 0;

	chunk_container_parser #(
		.LENGTH_BITS(ccp_pkg::LENGTH_BITS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Transaction monitor: predict on input, compare on output.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_byte(in_data);
			if (out_valid && out_ready)
				board.check_result(out_data);
		end
	end

	// Receiver: random back-pressure, or a long hold-off on request.
	initial begin
		out_ready = 1'b0;
		hold_done = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_done) begin
				hold_done = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	function void list_word(logic [31:0] w);
		list_q.insert(list_q.size(), w[31:24]);
		list_q.insert(list_q.size(), w[23:16]);
		list_q.insert(list_q.size(), w[15:8]);
		list_q.insert(list_q.size(), w[7:0]);
	endfunction

	function void file_word(logic [31:0] w);
		file_q.insert(file_q.size(), w[31:24]);
		file_q.insert(file_q.size(), w[23:16]);
		file_q.insert(file_q.size(), w[15:8]);
		file_q.insert(file_q.size(), w[7:0]);
	endfunction

	function void set_root_size(logic [31:0] w);
		file_q[4] = w[31:24];
		file_q[5] = w[23:16];
		file_q[6] = w[15:8];
		file_q[7] = w[7:0];
	endfunction

	function void add_chunk(chunk_shape_e shape);
		logic [31:0] id;
		logic [31:0] sz;
		logic [7:0]  bv;
		int          body_len;
		int          name_len;
		id = ccp_pkg::ID_INFO;
		sz = '0;
		case (shape)
			SH_HEAD: begin
				id = ccp_pkg::ID_HEAD;
				sz = $urandom_range(4, 24);
			end
			SH_HEAD_SMALL: begin
				id = ccp_pkg::ID_HEAD;
				sz = $urandom_range(0, 3);
			end
			SH_EMBF: begin
				id = ccp_pkg::ID_EMBF;
				sz = $urandom_range(2, 20);
			end
			SH_EMBF_SMALL: begin
				id = ccp_pkg::ID_EMBF;
				sz = $urandom_range(0, 1);
			end
			SH_NO_NAME, SH_UNTERMINATED: begin
				id = ccp_pkg::ID_EMBF;
				sz = $urandom_range(2, 10);
			end
			SH_INFO: sz = $urandom_range(1, 16);
			SH_OTHER: begin
				id = $urandom;
				sz = $urandom_range(1, 16);
			end
			SH_EMPTY: id = $urandom_range(0, 1) ? ccp_pkg::ID_INFO : 32'($urandom);
			SH_BAD_BOUNDS: begin
				case ($urandom_range(0, 3))
					0: id = ccp_pkg::ID_HEAD;
					1: id = ccp_pkg::ID_EMBF;
					2: id = ccp_pkg::ID_INFO;
					default: id = $urandom;
				endcase
				sz = $urandom | 32'h0010_0000;
			end
			default: ;
		endcase
		list_word(id);
		list_word(sz);
		body_len = (shape == SH_BAD_BOUNDS) ? $urandom_range(0, 6) : int'(sz);
		name_len = (sz > 1 && sz < 64) ? $urandom_range(1, sz - 1) : 1;
		for (int i = 0; i < body_len; i++) begin
			bv = 8'($urandom);
			case (shape)
				SH_HEAD: bv = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
				SH_EMBF: begin
					if (i < name_len)
						bv = 8'($urandom_range(1, 255));
					else if (i == name_len)
						bv = 8'd0;
				end
				SH_NO_NAME: if (i == 0) bv = 8'd0;
				SH_UNTERMINATED: bv = 8'($urandom_range(1, 255));
				default: ;
			endcase
			list_q.insert(list_q.size(), bv);
		end
		if (sz[0] && shape != SH_BAD_BOUNDS)
			list_q.insert(list_q.size(), 8'($urandom));
	endfunction

	function void build_file(bit broken);
		int n;
		int bad_at;
		list_q.delete();
		file_q.delete();
		n = $urandom_range(1, 6);
		bad_at = broken ? $urandom_range(0, n - 1) : -1;
		for (int i = 0; i < n; i++) begin
			if (i == bad_at)
				add_chunk(chunk_shape_e'($urandom_range(SH_BAD_BOUNDS, SH_UNTERMINATED)));
			else
				add_chunk(chunk_shape_e'($urandom_range(SH_HEAD, SH_EMPTY)));
		end
		// short tail that cannot hold a chunk header
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 7)) list_q.insert(list_q.size(), 8'($urandom));
		file_word(ccp_pkg::ID_CAT);
		file_word(list_q.size() + 4);
		file_word(ccp_pkg::ID_PRBM);
		foreach (list_q[i])
			file_q.insert(file_q.size(), list_q[i]);
		// bytes beyond the stated root size
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 5)) file_q.insert(file_q.size(), 8'($urandom));
	endfunction

	function void damage_header();
		int cut;
		case ($urandom_range(0, 5))
			0: file_q[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
			1: file_q[$urandom_range(8, 11)] ^= 8'($urandom_range(1, 255));
			2: set_root_size($urandom_range(0, 3));
			3: set_root_size(file_q.size() - 8 + $urandom_range(1, 40));
			4: set_root_size($urandom);
			default: begin
				cut = $urandom_range(1, file_q.size() - 1);
				file_q = file_q[0:cut-1];
			end
		endcase
	endfunction

	task automatic send_byte(logic [7:0] b, logic last);
		ccp_pkg::in_item_t it;
		it.in_byte = b;
		it.last_byte = last;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_file();
		foreach (file_q[i])
			send_byte(file_q[i], i == file_q.size() - 1);
	endtask

	task automatic send_random_file();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			build_file(1'b0);
		end else if (pick < 75) begin
			build_file(1'b1);
		end else if (pick < 90) begin
			build_file($urandom_range(0, 1));
			damage_header();
		end else begin
			file_q.delete();
			repeat ($urandom_range(1, 30)) file_q.insert(file_q.size(), 8'($urandom));
		end
		send_file();
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		hold_req = 0;
		bytes_sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest valid file: one EMBF chunk with a one-byte name
		file_q.delete();
		file_word(ccp_pkg::ID_CAT);
		file_word(32'd14);
		file_word(ccp_pkg::ID_PRBM);
		file_word(ccp_pkg::ID_EMBF);
		file_word(32'd2);
		file_q.insert(file_q.size(), 8'hFF);
		file_q.insert(file_q.size(), 8'h00);
		send_file();
		// one-byte file
		file_q.delete();
		file_q.insert(file_q.size(), 8'hFF);
		send_file();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 75 : 0;
			recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 28 : 0;
			send_random_file();
			if (ph == 1)
				drain_results();
			else
				hold_req <= hold_req + 1;
			while (bytes_sent < (ph + 1) * 700)
				send_random_file();
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
src/ccp_pkg.sv
src/ccp_verdict.sv
src/chunk_container_parser.sv
tb/tb_top.sv
